[sv/piecewise_linear_table_interp_assert.svh]
// Assertion shorthands used by the checker of this block.
`ifndef PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH
`define PIECEWISE_LINEAR_TABLE_INTERP_ASSERT_SVH

// same-cycle implication
`define PWL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PWL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pwl_pkg.sv]
`default_nettype none

package pwl_pkg;

  typedef logic [1:0] region_t;

  localparam region_t REGION_INTERP = 2'd0;
  localparam region_t REGION_BELOW  = 2'd1;
  localparam region_t REGION_ABOVE  = 2'd2;
  localparam region_t REGION_FLAT   = 2'd3;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 32;

endpackage

`default_nettype wire

[sv/piecewise_linear_table_interp.sv]
// Channel   | Direction | Content
// s_axis    | in        | tdata: entry_index, entry_x, entry_y, query_x; tuser: action
// m_axis    | out       | tdata: value; tuser: region
// cfg       | in        | point_count, written when cfg_wr_en is high
//
// A write request gives no result. A query runs a pipelined scan of the active entries
// (one entry a cycle from one read port), a shift-add multiply, a restoring divide and a
// final add. Clamped results skip the arithmetic. One request is in flight at a time;
// s_axis_tready is low while a query is worked on or its result waits to load.
// rst is synchronous; the table itself is not cleared and must be written first.
`default_nettype none

module piecewise_linear_table_interp #(
  parameter int TABLE_DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_wr_en,
  input  wire logic [4:0]                        cfg_wr_data,   // point_count
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [3:0] entry_index, [35:4] entry_x, [67:36] entry_y, [99:68] query_x
  input  wire logic [pwl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  input  wire logic                              s_axis_tuser,  // [0] action
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [pwl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,  // [31:0] value
  output pwl_pkg::region_t                       m_axis_tuser   // [1:0] region
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
  localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH, S_PREP, S_MUL, S_DIV, S_ADD, S_OUT
  } state_t;

  state_t state;

  logic [4:0]       point_count;
  logic [CW-1:0]    n_act;
  logic [CW-1:0]    n_reg;
  logic [AW-1:0]    n_last;

  logic [31:0]      xmem [TABLE_DEPTH];
  logic [31:0]      ymem [TABLE_DEPTH];
  logic [31:0]      xr, yr;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;

  logic [CW-1:0]    cnt;
  logic             issue;
  logic             rvalid;
  logic [AW-1:0]    ridx;
  logic signed [31:0] q;
  logic [31:0]      xprev, yprev;
  logic             x_ge;

  logic [32:0]      dy;
  logic [31:0]      num, den;
  logic [32:0]      mag;
  logic [65:0]      prod;
  logic [65:0]      prod_next;
  logic [33:0]      mul_sum;
  logic [5:0]       step;
  logic [31:0]      rem;
  logic [32:0]      qsh;
  logic [33:0]      div_diff;
  logic             div_ge;
  logic signed [34:0] add_sum;
  logic [31:0]      sat_value;

  logic [31:0]      res_value;
  pwl_pkg::region_t res_region;

  logic             s_accept;
  logic             out_load;

  assign s_axis_tready = (state == S_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_OUT) && (!m_axis_tvalid || m_axis_tready);

  // active count: zero acts as one, anything past the table acts as its depth
  always_comb begin
    if (point_count == 5'd0) begin
      n_act = CW'(1);
    end else if (32'(point_count) > 32'(TABLE_DEPTH)) begin
      n_act = CW'(TABLE_DEPTH);
    end else begin
      n_act = CW'(point_count);
    end
  end

  assign n_last = AW'(n_reg - CW'(1));

  assign wr_en   = s_accept && (s_axis_tuser == pwl_pkg::ACT_WRITE)
                   && (32'(s_axis_tdata[3:0]) < 32'(TABLE_DEPTH));
  assign wr_addr = AW'(s_axis_tdata[3:0]);

  assign issue   = (state == S_SRCH) && (cnt < n_reg);
  assign rd_addr = issue ? cnt[AW-1:0] : '0;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      xmem[wr_addr] <= s_axis_tdata[35:4];
      ymem[wr_addr] <= s_axis_tdata[67:36];
    end
    xr <= xmem[rd_addr];
    yr <= ymem[rd_addr];
  end

  assign x_ge = $signed(xr) >= q;

  // shift-add multiply, one multiplier bit a cycle
  assign mul_sum   = prod[65:32] + (prod[0] ? {1'b0, mag} : 34'd0);
  assign prod_next = {1'b0, mul_sum, prod[31:1]};

  // restoring divide, one quotient bit a cycle; rem stays below den
  assign div_diff = {1'b0, rem, qsh[32]} - {2'b00, den};
  assign div_ge   = !div_diff[33];

  assign add_sum = dy[32] ? ($signed({{3{yprev[31]}}, yprev}) - $signed({2'b00, qsh}))
                          : ($signed({{3{yprev[31]}}, yprev}) + $signed({2'b00, qsh}));

  always_comb begin
    if (add_sum > SAT_MAX) begin
      sat_value = 32'h7FFF_FFFF;
    end else if (add_sum < SAT_MIN) begin
      sat_value = 32'h8000_0000;
    end else begin
      sat_value = add_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      point_count   <= 5'd1;
      m_axis_tvalid <= 1'b0;
      rvalid        <= 1'b0;
      cnt           <= '0;
      step          <= '0;
    end else begin
      if (cfg_wr_en) begin
        point_count <= cfg_wr_data;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_accept && (s_axis_tuser == pwl_pkg::ACT_QUERY)) begin
            q      <= $signed(s_axis_tdata[99:68]);
            n_reg  <= n_act;
            cnt    <= '0;
            rvalid <= 1'b0;
            state  <= S_SRCH;
          end
        end

        S_SRCH: begin
          if (issue) begin
            cnt  <= cnt + CW'(1);
            ridx <= cnt[AW-1:0];
          end
          // the pipeline drains once the scan has its answer
          rvalid <= issue && !(rvalid && (x_ge || (ridx == n_last)));
          if (rvalid) begin
            if (x_ge) begin
              if (ridx == '0) begin
                res_value  <= yr;
                res_region <= pwl_pkg::REGION_BELOW;
                state      <= S_OUT;
              end else if (xr == xprev) begin
                res_value  <= yprev;
                res_region <= pwl_pkg::REGION_FLAT;
                state      <= S_OUT;
              end else begin
                dy    <= {yr[31], yr} - {yprev[31], yprev};
                num   <= q - $signed(xprev);
                den   <= xr - xprev;
                state <= S_PREP;
              end
            end else if (ridx == n_last) begin
              res_value  <= yr;
              res_region <= pwl_pkg::REGION_ABOVE;
              state      <= S_OUT;
            end else begin
              xprev <= xr;
              yprev <= yr;
            end
          end
        end

        S_PREP: begin
          mag   <= dy[32] ? (33'd0 - dy) : dy;
          prod  <= {34'd0, num};
          step  <= '0;
          state <= S_MUL;
        end

        S_MUL: begin
          prod <= prod_next;
          step <= (step == 6'd31) ? 6'd0 : step + 6'd1;
          if (step == 6'd31) begin
            // product is below den * 2^33, so its top 32 bits are below den
            rem   <= prod_next[64:33];
            qsh   <= prod_next[32:0];
            state <= S_DIV;
          end
        end

        S_DIV: begin
          rem  <= div_ge ? div_diff[31:0] : {rem[30:0], qsh[32]};
          qsh  <= {qsh[31:0], div_ge};
          step <= step + 6'd1;
          if (step == 6'd32) begin
            state <= S_ADD;
          end
        end

        S_ADD: begin
          res_value  <= sat_value;
          res_region <= pwl_pkg::REGION_INTERP;
          state      <= S_OUT;
        end

        S_OUT: begin
          if (out_load) begin
            m_axis_tdata  <= res_value;
            m_axis_tuser  <= res_region;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/pwl_check.sv]
`default_nettype none
`include "piecewise_linear_table_interp_assert.svh"

module pwl_check (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_axis_tvalid,
  input wire logic                           s_axis_tready,
  input wire logic                           s_axis_tuser,
  input wire logic                           m_axis_tvalid,
  input wire logic                           m_axis_tready,
  input wire logic [pwl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic [1:0]                     m_axis_tuser
);

  // a stalled result holds
  `PWL_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // one query at a time: no new request straight after a query
  `PWL_ASSERT_NEXT(a_query_busy, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == pwl_pkg::ACT_QUERY), !s_axis_tready, "request taken during a query")

  // a write gives no result
  `PWL_ASSERT_NEXT(a_write_silent, clk, rst, s_axis_tvalid && s_axis_tready && (s_axis_tuser == pwl_pkg::ACT_WRITE) && !m_axis_tvalid, !m_axis_tvalid, "result after a write request")

  // first-match search always brackets with x_lo < x_hi
  `PWL_ASSERT_NOW(a_no_flat, clk, rst, m_axis_tvalid, m_axis_tuser != pwl_pkg::REGION_FLAT, "flat segment reported")

endmodule

bind piecewise_linear_table_interp pwl_check u_pwl_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
